/* sv/mcm_pkg.sv */
// ----------------------------------------------------------------------------
// mcm_pkg: shared types and constants for the matrix chain cost block
// Cost width, status codes, split-pipeline control and saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

	localparam int unsigned COST_W   = 48;
	localparam int unsigned STATUS_W = 2;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;

	// control that travels with one split through the cost pipeline
	typedef struct packed {
		logic valid;
		logic first;   // first split of the interval
		logic last;    // last split of the interval
		logic zero_l;  // left sub-interval is a single matrix
		logic zero_r;  // right sub-interval is a single matrix
	} split_ctl_t;

	// add two costs, clamp at the top of the cost range
	function automatic logic [COST_W-1:0] sat_add(
		input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b
	);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* sv/matrix_chain_min_cost.sv */
// ----------------------------------------------------------------------------
// matrix_chain_min_cost: least scalar-multiplication cost of a matrix chain
// Loads chain dimensions into a memory, then runs the interval program over
// a cost-table memory, one split per cycle within an interval; reports the cost.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                 direction
//  -------   ---------------    ---------------------   ---------
//  item in   start / busy       dimension, last         into block
//  result    done (1 cycle)     min_cost, status        out of block
//
// Loading accepts items back to back; busy stays low while loading.
// After the item marked last, a chain of m = d-1 matrices is worked out one
//   split at a time through the cost pipeline, with a fetch and a drain
//   for each interval.
// Errors and single-matrix chains report in the cycle after the closing item.
// Reset clears control only; memories need no clearing. done cannot be held.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_min_cost
	import mcm_pkg::*;
#(
	parameter int unsigned MAX_MATRICES = 64,
	parameter int unsigned DIM_BITS     = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [DIM_BITS-1:0] dimension,
	input  wire logic                last,
	output logic                     done,
	output logic [COST_W-1:0]        min_cost,
	output logic [STATUS_W-1:0]      status
);

	localparam int unsigned SLOTS    = MAX_MATRICES + 1;
	localparam int unsigned IW       = $clog2(MAX_MATRICES);
	localparam int unsigned DAW      = $clog2(SLOTS);
	localparam int unsigned CW       = $clog2(SLOTS + 1);
	localparam int unsigned CT_DEPTH = 1 << (2 * IW);

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_SPLIT = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic                ovf_q;
	logic [IW-1:0]       lo_q, hi_q, split_q, last_mat_q;
	logic [DIM_BITS-1:0] dim_lo_q, dim_hi_q;

	logic                done_q;
	logic [COST_W-1:0]   min_cost_q;
	logic [STATUS_W-1:0] status_q;

	// memories and their registered read data
	logic [DIM_BITS-1:0] dim_mem [0:SLOTS-1];
	logic [COST_W-1:0]   cost_mem [0:CT_DEPTH-1];
	logic [DIM_BITS-1:0] dim_a_q, dim_b_q;
	logic [COST_W-1:0]   left_s1, right_s1;
	split_ctl_t          ctl_s1;

	logic                accept;
	logic                room;
	logic [CW-1:0]       cnt_new;
	logic [IW-1:0]       split_nx;
	logic [DAW-1:0]      dim_a_addr, dim_b_addr;
	logic [2*IW-1:0]     left_addr, right_addr, wr_addr;
	logic                fin_valid;
	logic [COST_W-1:0]   fin_cost;
	logic                cost_wr;
	logic                load_end;
	logic                calc_end;
	split_ctl_t          ctl_issue;

	assign busy     = (state_q != ST_LOAD);
	assign accept   = start && !busy;
	assign room     = (cnt_q < CW'(SLOTS));
	assign cnt_new  = room ? (cnt_q + CW'(1)) : cnt_q;
	assign split_nx = split_q + IW'(1);

	// dimension reads: port A walks lo then split+1, port B fetches hi+1
	assign dim_a_addr = (state_q == ST_SPLIT) ? (DAW'(split_q) + DAW'(1)) : DAW'(lo_q);
	assign dim_b_addr = DAW'(hi_q) + DAW'(1);

	// cost-table addresses: row lo / column hi
	assign left_addr  = {lo_q, split_q};
	assign right_addr = {split_nx, hi_q};
	assign wr_addr    = {lo_q, hi_q};
	assign cost_wr    = (state_q == ST_DRAIN) && fin_valid;

	// issue one split per cycle while in the split state
	always_comb begin
		ctl_issue        = '0;
		ctl_issue.valid  = (state_q == ST_SPLIT);
		ctl_issue.first  = (split_q == lo_q);
		ctl_issue.last   = (split_nx == hi_q);
		ctl_issue.zero_l = (split_q == lo_q);
		ctl_issue.zero_r = (split_nx == hi_q);
	end

	// dimension memory: write while loading, two registered reads
	always_ff @(posedge clk) begin
		if (accept && room) begin
			dim_mem[cnt_q[DAW-1:0]] <= dimension;
		end
		dim_a_q <= dim_mem[dim_a_addr];
		dim_b_q <= dim_mem[dim_b_addr];
	end

	// cost memory: write the interval minimum, read both sub-intervals
	always_ff @(posedge clk) begin
		if (cost_wr) begin
			cost_mem[wr_addr] <= fin_cost;
		end
		left_s1  <= cost_mem[left_addr];
		right_s1 <= cost_mem[right_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_issue;
		end
	end

	// hold the outer dimensions of the interval
	always_ff @(posedge clk) begin
		if ((state_q == ST_SPLIT) && (split_q == lo_q)) begin
			dim_lo_q <= dim_a_q;
			dim_hi_q <= dim_b_q;
		end
	end

	mcm_cost_pipe #(
		.DIM_BITS (DIM_BITS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.left_s1    (left_s1),
		.right_s1   (right_s1),
		.dim_lo     (dim_lo_q),
		.dim_mid_s1 (dim_a_q),
		.dim_hi     (dim_hi_q),
		.fin_valid  (fin_valid),
		.fin_cost   (fin_cost)
	);

	// a chain closes at once on error or single matrix, else after the last interval
	assign load_end = accept && last && (ovf_q || !room || (cnt_new <= CW'(2)));
	assign calc_end = (state_q == ST_DRAIN) && fin_valid &&
	                  (hi_q == last_mat_q) && (lo_q == '0);

	// raise done for one cycle after a chain closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= load_end || calc_end;
		end
	end

	// sequencer: load, then walk lengths, intervals and splits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			split_q    <= '0;
			last_mat_q <= '0;
			min_cost_q <= '0;
			status_q   <= STATUS_OK;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (last) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							if (ovf_q || !room) begin
								min_cost_q <= '0;
								status_q   <= STATUS_OVERFLOW;
							end else if (cnt_new < CW'(2)) begin
								min_cost_q <= '0;
								status_q   <= STATUS_SHORT;
							end else if (cnt_new == CW'(2)) begin
								min_cost_q <= '0;
								status_q   <= STATUS_OK;
							end else begin
								lo_q       <= '0;
								hi_q       <= IW'(1);
								last_mat_q <= IW'(cnt_new - CW'(2));
								state_q    <= ST_FETCH;
							end
						end else begin
							cnt_q <= cnt_new;
							if (!room) begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				ST_FETCH: begin
					split_q <= lo_q;
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					if (split_nx == hi_q) begin
						state_q <= ST_DRAIN;
					end else begin
						split_q <= split_nx;
					end
				end
				ST_DRAIN: begin
					if (fin_valid) begin
						if (hi_q == last_mat_q) begin
							if (lo_q == '0) begin
								min_cost_q <= fin_cost;
								status_q   <= STATUS_OK;
								state_q    <= ST_LOAD;
							end else begin
								hi_q    <= hi_q - lo_q + IW'(1);
								lo_q    <= '0;
								state_q <= ST_FETCH;
							end
						end else begin
							lo_q    <= lo_q + IW'(1);
							hi_q    <= hi_q + IW'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign min_cost = min_cost_q;
	assign status   = status_q;

endmodule

`default_nettype wire

/* sv/mcm_cost_pipe.sv */
// ----------------------------------------------------------------------------
// mcm_cost_pipe: per-split cost pipeline with running minimum
// Takes the two sub-interval costs and three dimensions of one split per
// cycle, forms left + right + d_lo*d_mid*d_hi and keeps the interval minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_cost_pipe
	import mcm_pkg::*;
#(
	parameter int unsigned DIM_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire split_ctl_t          ctl_s1,
	input  wire logic [COST_W-1:0]   left_s1,
	input  wire logic [COST_W-1:0]   right_s1,
	input  wire logic [DIM_BITS-1:0] dim_lo,
	input  wire logic [DIM_BITS-1:0] dim_mid_s1,
	input  wire logic [DIM_BITS-1:0] dim_hi,
	output logic                     fin_valid,
	output logic [COST_W-1:0]        fin_cost
);

	localparam int unsigned P1_W = 2 * DIM_BITS;
	localparam int unsigned P_W  = 3 * DIM_BITS;

	split_ctl_t          ctl_s2, ctl_s3, ctl_s4;
	logic [COST_W-1:0]   sum_s2, sum_s3, c_s4;
	logic [P1_W-1:0]     p1_s2;
	logic [P_W-1:0]      p_s3;
	logic [COST_W-1:0]   best_q;
	logic [COST_W-1:0]   best_nxt;
	logic [COST_W-1:0]   left_op, right_op;

	// single-matrix sub-intervals cost nothing
	assign left_op  = ctl_s1.zero_l ? '0 : left_s1;
	assign right_op = ctl_s1.zero_r ? '0 : right_s1;

	// advance control through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// sub-interval sum and first product, then full product, then total
	always_ff @(posedge clk) begin
		sum_s2 <= sat_add(left_op, right_op);
		p1_s2  <= P1_W'(dim_lo) * P1_W'(dim_mid_s1);
		sum_s3 <= sum_s2;
		p_s3   <= P_W'(p1_s2) * P_W'(dim_hi);
		c_s4   <= sat_add(sum_s3, COST_W'(p_s3));
	end

	// keep the smallest total of the interval
	assign best_nxt = (ctl_s4.first || (c_s4 < best_q)) ? c_s4 : best_q;

	always_ff @(posedge clk) begin
		if (ctl_s4.valid) begin
			best_q <= best_nxt;
		end
	end

	assign fin_valid = ctl_s4.valid && ctl_s4.last;
	assign fin_cost  = best_nxt;

endmodule

`default_nettype wire

/* tb/mcm_cost_ledger_pkg.sv */
// ----------------------------------------------------------------------------
// mcm_cost_ledger_pkg: chain cost prediction for the matrix chain testbench
// Collects each chain's dimensions as they are accepted. When a chain closes,
// it works out the expected cost and status and queues them. Results from
// the block are compared field by field, oldest expectation first.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_cost_ledger_pkg;

	import mcm_pkg::*;

	localparam int unsigned CHAIN_MATS  = 64;
	localparam int unsigned CHAIN_SLOTS = CHAIN_MATS + 1;
	localparam int unsigned DIM_W       = 12;
	localparam logic [63:0] COST_TOP    = (64'd1 << COST_W) - 64'd1;

	class chain_cost_ledger;
		logic [DIM_W-1:0]    dims [CHAIN_SLOTS];
		int unsigned         dim_total;
		bit                  overflowed;
		logic [COST_W-1:0]   cost_due [$];
		logic [STATUS_W-1:0] status_due [$];
		int unsigned         mismatches;

		function new();
			dim_total  = 0;
			overflowed = 0;
			mismatches = 0;
		endfunction

		// clamp a sum at the top of the cost range
		function logic [63:0] clamp_sum(input logic [63:0] a, input logic [63:0] b);
			logic [63:0] s;
			s = a + b;
			return (s > COST_TOP) ? COST_TOP : s;
		endfunction

		// interval program over matrices 0 .. mats-1
		function logic [63:0] least_chain_cost(input int unsigned mats);
			logic [63:0] span [CHAIN_MATS][CHAIN_MATS];
			logic [63:0] best;
			logic [63:0] trial;
			logic [63:0] prod;
			int unsigned len;
			int unsigned lo;
			int unsigned hi;
			int unsigned cut;
			for (lo = 0; lo < mats; lo++)
				span[lo][lo] = 64'd0;
			for (len = 2; len <= mats; len++) begin
				for (lo = 0; lo + len <= mats; lo++) begin
					hi = lo + len - 1;
					best = COST_TOP;
					for (cut = lo; cut < hi; cut++) begin
						trial = clamp_sum(span[lo][cut], span[cut+1][hi]);
						prod = {52'd0, dims[lo]} * {52'd0, dims[cut+1]} * {52'd0, dims[hi+1]};
						if (prod > COST_TOP)
							prod = COST_TOP;
						trial = clamp_sum(trial, prod);
						if (cut == lo || trial < best)
							best = trial;
					end
					span[lo][hi] = best;
				end
			end
			return span[0][mats-1];
		endfunction

		// take one accepted item; queue a result when it closes the chain
		function void note_dimension(input logic [DIM_W-1:0] d, input logic closes);
			logic [63:0] cost;
			if (dim_total < CHAIN_SLOTS) begin
				dims[dim_total] = d;
				dim_total++;
			end else begin
				overflowed = 1;
			end
			if (!closes)
				return;
			if (overflowed) begin
				cost_due.push_back('0);
				status_due.push_back(STATUS_OVERFLOW);
			end else if (dim_total < 2) begin
				cost_due.push_back('0);
				status_due.push_back(STATUS_SHORT);
			end else begin
				cost = least_chain_cost(dim_total - 1);
				cost_due.push_back(cost[COST_W-1:0]);
				status_due.push_back(STATUS_OK);
			end
			dim_total  = 0;
			overflowed = 0;
		endfunction

		function int pending();
			return cost_due.size();
		endfunction

		task flag_mismatch(input string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		// compare one result with the oldest expectation
		task check_result(input logic [COST_W-1:0] cost, input logic [STATUS_W-1:0] stat);
			logic [COST_W-1:0]   want_cost;
			logic [STATUS_W-1:0] want_stat;
			if (cost_due.size() == 0) begin
				flag_mismatch($sformatf("result with none due: cost %0d status %0d", cost, stat));
			end else begin
				want_cost = cost_due.pop_front();
				want_stat = status_due.pop_front();
				if (cost !== want_cost)
					flag_mismatch($sformatf("min_cost %0d, want %0d", cost, want_cost));
				if (stat !== want_stat)
					flag_mismatch($sformatf("status %0d, want %0d", stat, want_stat));
			end
		endtask
	endclass

endpackage

`default_nettype wire

/* tb/matrix_chain_min_cost_test.sv */
// ----------------------------------------------------------------------------
// matrix_chain_min_cost_test: self-checking bench for the matrix chain block
// Feeds directed chains (short, single matrix, zero and extreme dimensions),
// then random chains of mixed lengths including full and overflowing ones,
// with random gaps, and checks every reported cost and status.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_min_cost_test;

	timeunit 1ns;
	timeprecision 1ps;

	import mcm_pkg::*;
	import mcm_cost_ledger_pkg::*;

	localparam int unsigned ITEM_TARGET   = 850;
	localparam int unsigned CYCLE_LIMIT   = 3_000_000;
	localparam int unsigned SETTLE_CYCLES = 64;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic [DIM_W-1:0]    dimension = '0;
	logic                last      = 1'b0;
	logic                busy;
	logic                done;
	logic [COST_W-1:0]   min_cost;
	logic [STATUS_W-1:0] status;

	chain_cost_ledger ledger = new();
	int unsigned      cycle_count = 0;
	int unsigned      items_sent = 0;
	bit               steady = 0;

	matrix_chain_min_cost dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.dimension (dimension),
		.last      (last),
		.done      (done),
		.min_cost  (min_cost),
		.status    (status)
	);

	always #5 clk = ~clk;

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// check each result in the middle of its strobe cycle
	always @(negedge clk) begin
		if (arst_n && done)
			ledger.check_result(min_cost, status);
	end

	// present one item, hold it until the block takes it
	task automatic send_dimension(input logic [DIM_W-1:0] d, input logic closes);
		int unsigned gap;
		bit          taken;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		dimension <= d;
		last      <= closes;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		ledger.note_dimension(d, closes);
		items_sent++;
	endtask

	// drop start and hold until every due result has come
	task automatic wait_results();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DIM_W-1:0] pick_dimension();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 10)
			return $urandom_range(0, 1) ? 12'hFFF : 12'd1;
		if (r < 30)
			return DIM_W'($urandom_range(1, 16));
		return DIM_W'($urandom_range(1, 4095));
	endfunction

	initial begin
		int unsigned chain_no;
		int unsigned len;
		int unsigned r;
		int unsigned i;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short chain: one dimension only
		send_dimension(12'd7, 1'b1);
		// single matrix at the top of the range
		send_dimension(12'hFFF, 1'b0);
		send_dimension(12'hFFF, 1'b1);
		// two matrices with extreme sizes
		send_dimension(12'd1, 1'b0);
		send_dimension(12'hFFF, 1'b0);
		send_dimension(12'd1, 1'b1);
		// zero dimension inside the chain
		send_dimension(12'd10, 1'b0);
		send_dimension(12'd0, 1'b0);
		send_dimension(12'd20, 1'b0);
		send_dimension(12'd30, 1'b1);
		// textbook chain of four matrices
		send_dimension(12'd40, 1'b0);
		send_dimension(12'd20, 1'b0);
		send_dimension(12'd30, 1'b0);
		send_dimension(12'd10, 1'b0);
		send_dimension(12'd30, 1'b1);
		// all dimensions at the maximum
		steady = 1;
		repeat (3) send_dimension(12'hFFF, 1'b0);
		send_dimension(12'hFFF, 1'b1);
		steady = 0;
		// alternating bit patterns
		send_dimension(12'hAAA, 1'b0);
		send_dimension(12'h555, 1'b1);

		// let the directed part finish before random traffic
		wait_results();

		// full-capacity chain of maximum dimensions
		for (i = 0; i < CHAIN_SLOTS; i++)
			send_dimension(12'hFFF, i == CHAIN_SLOTS - 1);

		// random chains, mostly well formed, some short or overflowing
		chain_no = 0;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (chain_no == 0)
				len = CHAIN_SLOTS + 3;
			else if (r < 5)
				len = 1;
			else if (r < 7)
				len = CHAIN_SLOTS;
			else if (r < 9)
				len = $urandom_range(CHAIN_SLOTS + 1, CHAIN_SLOTS + 5);
			else if (r < 20)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(2, 12);
			steady = ($urandom_range(0, 3) == 0);
			for (i = 0; i < len; i++)
				send_dimension(pick_dimension(), i == len - 1);
			chain_no++;
		end
		steady = 0;

		// drain and watch for stray results
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
sv/mcm_pkg.sv
sv/mcm_cost_pipe.sv
sv/matrix_chain_min_cost.sv
tb/mcm_cost_ledger_pkg.sv
tb/matrix_chain_min_cost_test.sv
